// ----- hdl/lcdnw_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helpers for the character-LCD nibble writer.
// No dependencies; every other file in hdl/ refers to this package by scoped name.
package lcdnw_pkg;

    // Widest column limit the cursor logic supports.
    localparam int MAX_COLUMNS = 40;

    // Default depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // Operation codes.
    localparam logic [2:0] OP_COMMAND  = 3'd0;
    localparam logic [2:0] OP_CHAR     = 3'd1;
    localparam logic [2:0] OP_POSITION = 3'd2;
    localparam logic [2:0] OP_CLEAR    = 3'd3;
    localparam logic [2:0] OP_FLAG     = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_COLUMNS = 2'd0;
    localparam logic [1:0] CFG_ROWS    = 2'd1;
    localparam logic [1:0] CFG_EIGHT   = 2'd2;

    // Flag index that selects nothing.
    localparam logic [1:0] FLAG_NONE = 2'd3;

    // Display command bytes.
    localparam logic [7:0] CMD_CLEAR   = 8'h01;
    localparam logic [7:0] CMD_HOME    = 8'h02;
    localparam logic [7:0] CMD_CONTROL = 8'h08;
    localparam logic [7:0] CMD_ADDRESS = 8'h80;
    localparam logic [7:0] ROW_BASE    = 8'h40;
    localparam logic [3:0] NIBBLE_MASK = 4'hF;

    // Register select codes.
    localparam logic RS_COMMAND = 1'b0;
    localparam logic RS_DATA    = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [5:0] COLUMNS_RESET = 6'd16;
    localparam logic [2:0] ROWS_RESET    = 3'd2;

    typedef struct packed {
        logic [5:0] columns;
        logic [2:0] rows;
        logic       eight_bit;
    } cfg_t;

    // One queue entry: the bytes one input item sends. The second byte,
    // when present, always goes to the command register.
    typedef struct packed {
        logic       two_bytes;
        logic       rs0;
        logic [7:0] byte0;
        logic [7:0] byte1;
    } job_t;

    function automatic logic [7:0] addr_cmd(input logic [5:0] col, input logic [1:0] row);
        logic [7:0] base;
        base = (row != 2'd0) ? (CMD_ADDRESS | ROW_BASE) : CMD_ADDRESS;
        return base + {2'b00, col};
    endfunction

endpackage

// ----- hdl/char_lcd_nibble_writer_top.sv -----
`timescale 1ns / 1ps
// The first bus transfer of an operation goes through the queue entry, the back-end job
// register and the output register. Throughput: one bus transfer per cycle while m_tready
// is high, 1 to 4 transfers per operation as set by the back-end sequencer; the front end
// takes one operation per cycle while the queue has room.
// Reset: aresetn is synchronous, active low; it clears cursor, flags, queue and
// output, and returns the registers to 16 columns, 2 rows and 4-bit mode.
module char_lcd_nibble_writer_top #(
    // Number of byte jobs the queue between front and back holds.
    parameter int QUEUE_DEPTH = lcdnw_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,

    // Configuration write channel. Index 0 columns_in_use, 1 rows_in_use,
    // 2 eight_bit_bus; other indexes are accepted and ignored.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [5:0]  cfg_data,

    // Operation input.
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata: byte_value[7:0], column[13:8], row[15:14], flag_index[17:16],
    // flag_on[18], zero padding [23:19].
    input  logic [23:0] s_tdata,
    // s_tuser: op[2:0].
    input  logic [2:0]  s_tuser,

    // Bus transfer output.
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata: bus_value[7:0].
    output logic [7:0]  m_tdata,
    // m_tuser: reg_select[0].
    output logic        m_tuser,
    // m_tlast: last_of_run, high on the final transfer of an operation.
    output logic        m_tlast
);

    // Configuration registers. Writes are only expected while the block is idle,
    // so both halves read them directly.
    lcdnw_pkg::cfg_t cfg_reg, cfg_next;

    lcdnw_pkg::job_t push_job;
    lcdnw_pkg::job_t head_job;
    logic            push;
    logic            not_full;
    logic            not_empty;
    logic            pop;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                lcdnw_pkg::CFG_COLUMNS: cfg_next.columns   = cfg_data;
                lcdnw_pkg::CFG_ROWS:    cfg_next.rows      = cfg_data[2:0];
                lcdnw_pkg::CFG_EIGHT:   cfg_next.eight_bit = cfg_data[0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.columns   <= lcdnw_pkg::COLUMNS_RESET;
            cfg_reg.rows      <= lcdnw_pkg::ROWS_RESET;
            cfg_reg.eight_bit <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // The front takes an operation whenever the queue has room, even while the
    // back end is still sending earlier transfers or the output is stalled.
    assign s_tready = not_full;

    lcdnw_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .item_valid (s_tvalid),
        .item_ready (s_tready),
        .op         (s_tuser),
        .byte_value (s_tdata[7:0]),
        .column     (s_tdata[13:8]),
        .row        (s_tdata[15:14]),
        .flag_index (s_tdata[17:16]),
        .flag_on    (s_tdata[18]),
        .push       (push),
        .push_job   (push_job)
    );

    // Operations that send nothing (bad position, unknown flag or op) are
    // accepted but never enter the queue.
    lcdnw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_job  (push_job),
        .not_full  (not_full),
        .pop       (pop),
        .not_empty (not_empty),
        .head_job  (head_job)
    );

    // The back end fetches the next job in the same cycle it emits the final
    // transfer of the current one, so transfers leave without gaps.
    lcdnw_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .eight_bit (cfg_reg.eight_bit),
        .job_valid (not_empty),
        .job       (head_job),
        .job_pop   (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_rs    (m_tuser),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

// ----- hdl/lcdnw_front.sv -----
`timescale 1ns / 1ps
// Front end: decodes one operation per cycle while the queue has room, keeps cursor and
// control flags, and pushes the bytes to send into the queue. Depends on lcdnw_pkg.
module lcdnw_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  lcdnw_pkg::cfg_t   cfg,
    input  logic              item_valid,
    input  logic              item_ready,
    input  logic [2:0]        op,
    input  logic [7:0]        byte_value,
    input  logic [5:0]        column,
    input  logic [1:0]        row,
    input  logic [1:0]        flag_index,
    input  logic              flag_on,
    output logic              push,
    output lcdnw_pkg::job_t   push_job
);

    logic [5:0] col_reg, col_next;
    logic [1:0] row_reg, row_next;
    logic [2:0] flags_reg, flags_next;

    logic [6:0] col_limit;
    logic [2:0] row_limit;
    logic [5:0] col_inc;
    logic [1:0] row_inc;
    logic       col_wrap;
    logic       row_wrap;
    logic [1:0] row_after;
    logic [2:0] flag_bit;
    logic [2:0] flags_upd;
    logic       emit;

    // Clamp the limits into their legal ranges.
    always_comb begin
        if (cfg.columns == 6'd0) begin
            col_limit = 7'd1;
        end else if ({1'b0, cfg.columns} > 7'(lcdnw_pkg::MAX_COLUMNS)) begin
            col_limit = 7'(lcdnw_pkg::MAX_COLUMNS);
        end else begin
            col_limit = {1'b0, cfg.columns};
        end
        if (cfg.rows == 3'd0) begin
            row_limit = 3'd1;
        end else if (cfg.rows > 3'd4) begin
            row_limit = 3'd4;
        end else begin
            row_limit = cfg.rows;
        end
    end

    always_comb begin
        col_inc   = col_reg + 6'd1;
        col_wrap  = (col_inc == 6'd0) || ({1'b0, col_inc} >= col_limit);
        row_inc   = row_reg + 2'd1;
        row_wrap  = (row_inc == 2'd0) || ({1'b0, row_inc} >= row_limit);
        row_after = row_wrap ? 2'd0 : row_inc;
        flag_bit  = 3'b100 >> flag_index;
        flags_upd = flag_on ? (flags_reg | flag_bit) : (flags_reg & ~flag_bit);
    end

    always_comb begin
        col_next           = col_reg;
        row_next           = row_reg;
        flags_next         = flags_reg;
        emit               = 1'b0;
        push_job.two_bytes = 1'b0;
        push_job.rs0       = lcdnw_pkg::RS_COMMAND;
        push_job.byte0     = byte_value;
        push_job.byte1     = lcdnw_pkg::CMD_HOME;
        case (op)
            lcdnw_pkg::OP_COMMAND: begin
                emit = 1'b1;
            end
            lcdnw_pkg::OP_CHAR: begin
                emit               = 1'b1;
                push_job.rs0       = lcdnw_pkg::RS_DATA;
                push_job.two_bytes = col_wrap;
                push_job.byte1     = lcdnw_pkg::addr_cmd(6'd0, row_after);
                if (col_wrap) begin
                    col_next = 6'd0;
                    row_next = row_after;
                end else begin
                    col_next = col_inc;
                end
            end
            lcdnw_pkg::OP_POSITION: begin
                if (({1'b0, column} < col_limit) && ({1'b0, row} < row_limit)) begin
                    emit           = 1'b1;
                    push_job.byte0 = lcdnw_pkg::addr_cmd(column, row);
                    col_next       = column;
                    row_next       = row;
                end
            end
            lcdnw_pkg::OP_CLEAR: begin
                emit               = 1'b1;
                push_job.two_bytes = 1'b1;
                push_job.byte0     = lcdnw_pkg::CMD_CLEAR;
                push_job.byte1     = lcdnw_pkg::CMD_HOME;
                col_next           = 6'd0;
                row_next           = 2'd0;
            end
            lcdnw_pkg::OP_FLAG: begin
                if (flag_index != lcdnw_pkg::FLAG_NONE) begin
                    emit           = 1'b1;
                    flags_next     = flags_upd;
                    push_job.byte0 = lcdnw_pkg::CMD_CONTROL | {5'd0, flags_upd};
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    assign push = item_valid && item_ready && emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= 6'd0;
            row_reg   <= 2'd0;
            flags_reg <= 3'd0;
        end else if (item_valid && item_ready) begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            flags_reg <= flags_next;
        end
    end

endmodule

// ----- hdl/lcdnw_queue.sv -----
`timescale 1ns / 1ps
// Small register queue of byte jobs between front and back.
// Depends on lcdnw_pkg for the entry type.
module lcdnw_queue #(
    parameter int DEPTH = lcdnw_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  lcdnw_pkg::job_t   push_job,
    output logic              not_full,
    input  logic              pop,
    output logic              not_empty,
    output lcdnw_pkg::job_t   head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lcdnw_pkg::job_t  entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign not_full  = (count_reg != CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_job  = entry_reg[rd_reg];
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        count_next = count_reg;
        if (do_push) begin
            wr_next = (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_next = (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_reg] <= push_job;
        end
    end

endmodule

// ----- hdl/lcdnw_back.sv -----
`timescale 1ns / 1ps
// Back end: splits queued byte jobs into bus transfers, one per cycle while the output
// is not stalled, into an output register. Depends on lcdnw_pkg.
module lcdnw_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              eight_bit,
    input  logic              job_valid,
    input  lcdnw_pkg::job_t   job,
    output logic              job_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              out_rs,
    output logic [7:0]        out_data,
    output logic              out_last
);

    lcdnw_pkg::job_t cur_reg, cur_next;
    logic            busy_reg, busy_next;
    logic            sel_reg, sel_next;
    logic            nib_reg, nib_next;
    logic            valid_reg, valid_next;
    logic            rs_reg, rs_next;
    logic [7:0]      data_reg, data_next;
    logic            last_reg, last_next;

    logic       advance;
    logic [7:0] cur_byte;
    logic       byte_done;
    logic       job_done;

    always_comb begin
        advance   = busy_reg && (!valid_reg || out_ready);
        cur_byte  = sel_reg ? cur_reg.byte1 : cur_reg.byte0;
        byte_done = eight_bit || nib_reg;
        job_done  = byte_done && (sel_reg || !cur_reg.two_bytes);
        job_pop   = job_valid && (!busy_reg || (advance && job_done));
    end

    always_comb begin
        cur_next   = cur_reg;
        busy_next  = busy_reg;
        sel_next   = sel_reg;
        nib_next   = nib_reg;
        valid_next = valid_reg;
        rs_next    = rs_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        if (out_ready) begin
            valid_next = 1'b0;
        end
        if (advance) begin
            valid_next = 1'b1;
            rs_next    = sel_reg ? lcdnw_pkg::RS_COMMAND : cur_reg.rs0;
            last_next  = job_done;
            if (eight_bit) begin
                data_next = cur_byte;
            end else if (nib_reg) begin
                data_next = {4'd0, cur_byte[3:0] & lcdnw_pkg::NIBBLE_MASK};
            end else begin
                data_next = {4'd0, cur_byte[7:4] & lcdnw_pkg::NIBBLE_MASK};
            end
            if (!byte_done) begin
                nib_next = 1'b1;
            end else begin
                nib_next = 1'b0;
                if (!job_done) begin
                    sel_next = 1'b1;
                end else begin
                    busy_next = 1'b0;
                end
            end
        end
        if (job_pop) begin
            cur_next  = job;
            busy_next = 1'b1;
            sel_next  = 1'b0;
            nib_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            sel_reg   <= 1'b0;
            nib_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            sel_reg   <= sel_next;
            nib_reg   <= nib_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg  <= cur_next;
        rs_reg   <= rs_next;
        data_reg <= data_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_rs    = rs_reg;
    assign out_data  = data_reg;
    assign out_last  = last_reg;

endmodule

// ----- tb/lcd_transfer_checker.sv -----
`timescale 1ns / 1ps
// Checker for the character-LCD nibble writer: predicts the bus transfers of each
// operation and compares them with the output stream. Depends on lcdnw_pkg only.
module lcd_transfer_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [5:0]  cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    output int          mismatches,
    output int          transfers_due
);
    import lcdnw_pkg::*;

    typedef struct packed {
        logic       rs;
        logic [7:0] value;
        logic       last;
    } bus_xfer_t;

    bus_xfer_t  due_q[$];
    bus_xfer_t  head;

    logic [5:0] columns_reg;
    logic [2:0] rows_reg;
    logic       eight_reg;
    logic [5:0] cur_col;
    logic [1:0] cur_row;
    logic [2:0] ctrl_flags;

    function automatic int column_limit();
        if (columns_reg == 6'd0) return 1;
        if (columns_reg > MAX_COLUMNS) return MAX_COLUMNS;
        return columns_reg;
    endfunction

    function automatic int row_limit();
        if (rows_reg == 3'd0) return 1;
        if (rows_reg > 3'd4) return 4;
        return rows_reg;
    endfunction

    // Set-address command: rows other than the first start at the second line base.
    function automatic logic [7:0] address_of(input logic [5:0] col, input logic [1:0] row);
        logic [7:0] base;
        base = CMD_ADDRESS | ((row != 2'd0) ? ROW_BASE : 8'h00);
        return base + {2'b00, col};
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("%0t: %s", $time, msg);
    endtask

    // Works out the bytes one operation sends, updates the cursor and flags, and
    // queues the resulting bus transfers.
    task automatic translate_operation(input logic [2:0] op, input logic [23:0] data);
        logic [7:0] byte_value;
        logic [5:0] column;
        logic [1:0] row;
        logic [1:0] flag_index;
        logic       flag_on;
        logic [7:0] seq_byte[2];
        logic       seq_rs[2];
        int         nbytes;
        logic [2:0] flag_bit;
        bus_xfer_t  x;
        byte_value = data[7:0];
        column     = data[13:8];
        row        = data[15:14];
        flag_index = data[17:16];
        flag_on    = data[18];
        nbytes     = 0;
        case (op)
            OP_COMMAND: begin
                seq_rs[0]   = RS_COMMAND;
                seq_byte[0] = byte_value;
                nbytes      = 1;
            end
            OP_CHAR: begin
                seq_rs[0]   = RS_DATA;
                seq_byte[0] = byte_value;
                nbytes      = 1;
                cur_col     = cur_col + 6'd1;
                // A cursor left beyond a shrunken limit wraps as well.
                if (cur_col == 6'd0 || cur_col >= column_limit()) begin
                    cur_col = 6'd0;
                    cur_row = cur_row + 2'd1;
                    if (cur_row == 2'd0 || cur_row >= row_limit())
                        cur_row = 2'd0;
                    seq_rs[1]   = RS_COMMAND;
                    seq_byte[1] = address_of(cur_col, cur_row);
                    nbytes      = 2;
                end
            end
            OP_POSITION: begin
                if (column < column_limit() && row < row_limit()) begin
                    seq_rs[0]   = RS_COMMAND;
                    seq_byte[0] = address_of(column, row);
                    nbytes      = 1;
                    cur_col     = column;
                    cur_row     = row;
                end
            end
            OP_CLEAR: begin
                seq_rs[0]   = RS_COMMAND;
                seq_byte[0] = CMD_CLEAR;
                seq_rs[1]   = RS_COMMAND;
                seq_byte[1] = CMD_HOME;
                nbytes      = 2;
                cur_col     = 6'd0;
                cur_row     = 2'd0;
            end
            OP_FLAG: begin
                if (flag_index != FLAG_NONE) begin
                    flag_bit    = 3'b100 >> flag_index;
                    ctrl_flags  = flag_on ? (ctrl_flags | flag_bit) : (ctrl_flags & ~flag_bit);
                    seq_rs[0]   = RS_COMMAND;
                    seq_byte[0] = CMD_CONTROL | {5'b00000, ctrl_flags};
                    nbytes      = 1;
                end
            end
            default: ;
        endcase
        for (int i = 0; i < nbytes; i++) begin
            x.rs = seq_rs[i];
            if (eight_reg) begin
                x.value = seq_byte[i];
                x.last  = (i == nbytes - 1);
                due_q.push_back(x);
            end else begin
                x.value = {4'h0, seq_byte[i][7:4]};
                x.last  = 1'b0;
                due_q.push_back(x);
                x.value = {4'h0, seq_byte[i][3:0]};
                x.last  = (i == nbytes - 1);
                due_q.push_back(x);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            columns_reg = COLUMNS_RESET;
            rows_reg    = ROWS_RESET;
            eight_reg   = 1'b0;
            cur_col     = 6'd0;
            cur_row     = 2'd0;
            ctrl_flags  = 3'd0;
            mismatches  = 0;
            due_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_COLUMNS: columns_reg = cfg_data;
                    CFG_ROWS:    rows_reg    = cfg_data[2:0];
                    CFG_EIGHT:   eight_reg   = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                translate_operation(s_tuser, s_tdata);
            if (m_tvalid && m_tready) begin
                if (due_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected transfer: rs=%0d data=%02h last=%0d",
                                              m_tuser, m_tdata, m_tlast));
                end else begin
                    head = due_q.pop_front();
                    if (m_tuser !== head.rs)
                        report_mismatch($sformatf("reg_select: got %0d, expected %0d",
                                                  m_tuser, head.rs));
                    if (m_tdata !== head.value)
                        report_mismatch($sformatf("bus_value: got %02h, expected %02h",
                                                  m_tdata, head.value));
                    if (m_tlast !== head.last)
                        report_mismatch($sformatf("last_of_run: got %0d, expected %0d",
                                                  m_tlast, head.last));
                end
            end
        end
        transfers_due = due_q.size();
    end

endmodule

// ----- tb/tb_char_lcd_nibble_writer_top.sv -----
`timescale 1ns / 1ps
// Testbench top for the character-LCD nibble writer: drives configuration and
// operations, applies random back-pressure, and gives the verdict.
// Depends on lcdnw_pkg, char_lcd_nibble_writer_top and lcd_transfer_checker.
module tb_char_lcd_nibble_writer_top;
    import lcdnw_pkg::*;

    // Codes the block must ignore: operations past the flag operation, and the
    // register index past the bus-width register.
    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;
    localparam logic [1:0] CFG_UNUSED   = 2'd3;

    // Control flag indexes.
    localparam logic [1:0] FLAG_DISPLAY = 2'd0;
    localparam logic [1:0] FLAG_CURSOR  = 2'd1;
    localparam logic [1:0] FLAG_BLINK   = 2'd2;

    localparam int NUM_PHASES      = 8;
    localparam int OPS_PER_PHASE   = 45;
    localparam int IDLE_PERCENT    = 17;
    localparam int SETTLE_CYCLES   = 8;

    // Register settings per random phase. Phase 5 draws its own values, and phase 1,
    // with 40 columns by 4 rows, runs with no idling on either side.
    localparam logic [5:0] PHASE_COLUMNS [NUM_PHASES] = '{6'd1, 6'd40, 6'd0, 6'd63,
                                                         6'd5, 6'd0, 6'd2, 6'd16};
    localparam logic [2:0] PHASE_ROWS    [NUM_PHASES] = '{3'd1, 3'd4, 3'd0, 3'd7,
                                                         3'd3, 3'd0, 3'd4, 3'd2};
    localparam logic       PHASE_EIGHT   [NUM_PHASES] = '{1'b1, 1'b0, 1'b0, 1'b1,
                                                         1'b1, 1'b0, 1'b0, 1'b1};
    localparam int         RANDOM_PHASE  = 5;
    localparam int         STEADY_PHASE  = 1;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [5:0]  cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic [2:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    int          mismatches;
    int          transfers_due;

    // Random idling on both sides is on unless a phase turns it off.
    logic        idle_on = 1'b1;

    // Effective display size as the block sees it, for aiming set-position
    // operations at valid targets.
    int          eff_columns = 16;
    int          eff_rows    = 2;

    char_lcd_nibble_writer_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    lcd_transfer_checker transfer_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .mismatches    (mismatches),
        .transfers_due (transfers_due)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Output back-pressure: the receiver is stalled at random about 17 percent of the time
    // while idling is on, and never otherwise.
    always @(posedge aclk) begin
        m_tready <= !idle_on || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Packs the operation fields into the tdata layout, byte_value in the lowest bits.
    function automatic logic [23:0] op_fields(input logic [7:0] byte_value,
                                              input logic [5:0] column,
                                              input logic [1:0] row,
                                              input logic [1:0] flag_index,
                                              input logic       flag_on);
        return {5'b00000, flag_on, flag_index, row, column, byte_value};
    endfunction

    // Writes all three registers, plus the ignored index, in back-to-back
    // transfers. Only called while the block is idle. Upper data bits that a
    // register does not use are randomized, since the block must drop them.
    task automatic apply_settings(input logic [5:0] columns, input logic [2:0] rows,
                                  input logic eight_bit);
        logic [5:0] values[4];
        logic [1:0] indexes[4];
        values[0]  = columns;
        values[1]  = {3'($urandom_range(7)), rows};
        values[2]  = {5'($urandom_range(31)), eight_bit};
        values[3]  = 6'($urandom_range(63));
        indexes[0] = CFG_COLUMNS;
        indexes[1] = CFG_ROWS;
        indexes[2] = CFG_EIGHT;
        indexes[3] = CFG_UNUSED;
        cfg_valid <= 1'b1;
        for (int i = 0; i < 4; i++) begin
            cfg_index <= indexes[i];
            cfg_data  <= values[i];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        eff_columns = (columns == 6'd0) ? 1 : (columns > MAX_COLUMNS) ? MAX_COLUMNS : columns;
        eff_rows    = (rows == 3'd0) ? 1 : (rows > 3'd4) ? 4 : rows;
    endtask

    // Offers one operation and returns at the edge where it is accepted. tvalid
    // stays high afterwards so that back-to-back operations need no dead cycle.
    task automatic send_op(input logic [2:0] op, input logic [23:0] fields);
        if (idle_on) begin
            while ($urandom_range(99) < IDLE_PERCENT) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= fields;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Waits until every predicted transfer has come out, then waits out SETTLE_CYCLES
    // so that an operation with no output has also left the pipeline.
    task automatic settle();
        do @(posedge aclk); while (transfers_due != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One random operation. Character writes dominate so that the cursor wraps
    // often; most set-position targets are in range. Ignored operations are
    // flagged so they do not count toward the run length.
    task automatic send_random_op(output bit counted);
        int          pick;
        logic [7:0]  byte_value;
        logic [5:0]  column;
        logic [1:0]  row;
        logic [1:0]  flag_index;
        logic        flag_on;
        logic [2:0]  op;
        pick       = $urandom_range(99);
        byte_value = 8'($urandom_range(255));
        column     = 6'($urandom_range(63));
        row        = 2'($urandom_range(3));
        flag_index = 2'($urandom_range(3));
        flag_on    = 1'($urandom_range(1));
        counted    = 1'b1;
        if (pick < 45) begin
            op = OP_CHAR;
        end else if (pick < 60) begin
            op = OP_POSITION;
            if ($urandom_range(99) < 80) begin
                column = 6'($urandom_range(eff_columns - 1));
                row    = 2'($urandom_range(eff_rows - 1));
            end
        end else if (pick < 70) begin
            op = OP_COMMAND;
        end else if (pick < 78) begin
            op = OP_CLEAR;
        end else if (pick < 94) begin
            op = OP_FLAG;
        end else begin
            op      = 3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
            counted = 1'b0;
        end
        send_op(op, op_fields(byte_value, column, row, flag_index, flag_on));
    endtask

    initial begin
        int  done_ops;
        bit  counted;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part at the reset-size display of 16 columns by 2 rows in
        // 4-bit mode, written explicitly so every register gets a transfer.
        apply_settings(COLUMNS_RESET, ROWS_RESET, 1'b0);
        send_op(OP_COMMAND,  op_fields(8'h00, 6'd0,  2'd0, FLAG_DISPLAY, 1'b0));
        send_op(OP_COMMAND,  op_fields(8'hFF, 6'd63, 2'd3, FLAG_NONE,    1'b1));
        send_op(OP_CHAR,     op_fields(8'hFF, 6'd63, 2'd3, FLAG_NONE,    1'b1));
        send_op(OP_CHAR,     op_fields(8'h00, 6'd0,  2'd0, FLAG_DISPLAY, 1'b0));
        send_op(OP_POSITION, op_fields(8'h00, 6'd0,  2'd0, FLAG_DISPLAY, 1'b0));
        // Last valid cell; the next character wraps the row back to the top.
        send_op(OP_POSITION, op_fields(8'hFF, 6'd15, 2'd1, FLAG_NONE,    1'b1));
        send_op(OP_CHAR,     op_fields(8'h41, 6'd0,  2'd0, FLAG_DISPLAY, 1'b0));
        // Targets off the display produce nothing and keep the cursor.
        send_op(OP_POSITION, op_fields(8'h00, 6'd16, 2'd0, FLAG_DISPLAY, 1'b0));
        send_op(OP_POSITION, op_fields(8'h00, 6'd0,  2'd2, FLAG_DISPLAY, 1'b0));
        send_op(OP_POSITION, op_fields(8'hFF, 6'd63, 2'd3, FLAG_NONE,    1'b1));
        send_op(OP_CLEAR,    op_fields(8'hFF, 6'd63, 2'd3, FLAG_NONE,    1'b1));
        send_op(OP_FLAG,     op_fields(8'h00, 6'd0,  2'd0, FLAG_DISPLAY, 1'b1));
        send_op(OP_FLAG,     op_fields(8'h00, 6'd0,  2'd0, FLAG_CURSOR,  1'b1));
        send_op(OP_FLAG,     op_fields(8'h00, 6'd0,  2'd0, FLAG_BLINK,   1'b1));
        // The unused flag index changes nothing.
        send_op(OP_FLAG,     op_fields(8'h00, 6'd0,  2'd0, FLAG_NONE,    1'b1));
        send_op(OP_FLAG,     op_fields(8'h00, 6'd0,  2'd0, FLAG_BLINK,   1'b0));
        send_op(OP_FLAG,     op_fields(8'h00, 6'd0,  2'd0, FLAG_DISPLAY, 1'b0));
        for (int op = OP_UNUSED_LO; op <= OP_UNUSED_HI; op++)
            send_op(3'(op), op_fields(8'hFF, 6'd63, 2'd3, FLAG_NONE, 1'b1));
        // A wrap from the first row lands on the second-line base address.
        send_op(OP_POSITION, op_fields(8'h00, 6'd15, 2'd0, FLAG_DISPLAY, 1'b0));
        send_op(OP_CHAR,     op_fields(8'h7E, 6'd0,  2'd0, FLAG_DISPLAY, 1'b0));
        s_tvalid <= 1'b0;
        settle();

        // Random phases. Each one changes the registers on an idle block; the
        // cursor left over from a larger display tests the shrunken-limit wrap.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase == RANDOM_PHASE)
                apply_settings(6'($urandom_range(MAX_COLUMNS, 1)), 3'($urandom_range(4, 1)),
                               1'($urandom_range(1)));
            else
                apply_settings(PHASE_COLUMNS[phase], PHASE_ROWS[phase], PHASE_EIGHT[phase]);
            idle_on  = (phase != STEADY_PHASE);
            done_ops = 0;
            while (done_ops < OPS_PER_PHASE) begin
                send_random_op(counted);
                if (counted)
                    done_ops++;
            end
            s_tvalid <= 1'b0;
            idle_on  = 1'b1;
            settle();
        end

        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Guards against a hung handshake; far beyond the slowest correct run.
    initial begin
        #1000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
